[rtl/core/c3mp_pkg.sv]
package c3mp_pkg;

  // Field widths that are fixed by the interface.
  localparam int IMG_W    = 7;
  localparam int OUT_BITS = 20;

  // Limits and reset values of the configuration.
  localparam int               MIN_WIDTH  = 4;
  localparam logic [IMG_W-1:0] IMG_W_RST  = 7'd64;
  localparam int               KERNEL_CENTRE = 8;
  localparam int               KERNEL_EDGE   = -1;

  // Saturation bounds of a convolution result.
  localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH = 2'd0,
    REG_KERNEL_TOP  = 2'd1,
    REG_KERNEL_MID  = 2'd2,
    REG_KERNEL_BOT  = 2'd3
  } cfg_reg_e;

  // Control that travels with every pixel beat down the pipeline.
  typedef struct packed {
    logic valid;
    logic act;
    logic odd_row;
    logic odd_col;
    logic row_end;
    logic frame_last;
  } pool_ctrl_t;

  // Larger of two pooled candidates.
  function automatic logic signed [OUT_BITS-1:0] pool_max(
    input logic signed [OUT_BITS-1:0] a,
    input logic signed [OUT_BITS-1:0] b
  );
    return (b >= a) ? b : a;
  endfunction

endpackage

[rtl/core/c3mp_line_window.sv]
module c3mp_line_window
  import c3mp_pkg::*;
#(
  parameter int PIXEL_BITS = 8,
  parameter int MAX_WIDTH  = 64,
  parameter int PC_W       = 5,
  parameter int ADDR_W     = $clog2(MAX_WIDTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  pool_ctrl_t                 ctrl_i,
  input  logic [PC_W-1:0]            pc_i,
  input  logic [ADDR_W-1:0]          addr_i,
  input  logic [PIXEL_BITS-1:0]      pixel_i,
  output pool_ctrl_t                 ctrl_o,
  output logic [PC_W-1:0]            pc_o,
  output logic [8:0][PIXEL_BITS-1:0] taps_o
);

  logic [PIXEL_BITS-1:0] line_a [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] line_b [MAX_WIDTH];

  pool_ctrl_t            s1_ctrl_q, win_ctrl_q;
  logic [PC_W-1:0]       s1_pc_q, win_pc_q;
  logic [ADDR_W-1:0]     s1_addr_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [PIXEL_BITS-1:0] rd_a_q, rd_b_q;
  logic                  byp_q;
  logic [PIXEL_BITS-1:0] byp_a_q, byp_b_q;
  logic [PIXEL_BITS-1:0] a_eff, b_eff;

  logic [2:0][2:0][PIXEL_BITS-1:0] win_q, win_d;

  // Line store reads for the beat being accepted.
  always_ff @(posedge clk_i) begin
    if (adv_i && ctrl_i.valid) begin
      rd_a_q <= line_a[addr_i];
      rd_b_q <= line_b[addr_i];
    end
  end

  // Line store writes for the beat leaving the first stage.
  always_ff @(posedge clk_i) begin
    if (adv_i && s1_ctrl_q.valid) begin
      line_a[s1_addr_q] <= s1_pix_q;
      line_b[s1_addr_q] <= a_eff;
    end
  end

  // A beat that lands on the column being written in the same cycle sees the
  // old contents, so the fresh values are forwarded instead.
  always_ff @(posedge clk_i) begin
    if (adv_i && ctrl_i.valid) begin
      byp_q   <= s1_ctrl_q.valid && (s1_addr_q == addr_i);
      byp_a_q <= s1_pix_q;
      byp_b_q <= a_eff;
    end
  end

  assign a_eff = byp_q ? byp_a_q : rd_a_q;
  assign b_eff = byp_q ? byp_b_q : rd_b_q;

  // First stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '0;
    end else if (adv_i) begin
      s1_ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_pc_q   <= pc_i;
      s1_addr_q <= addr_i;
      s1_pix_q  <= pixel_i;
    end
  end

  // The window shifts left by one column and takes the new column on the right.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = b_eff;
    win_d[1][2] = a_eff;
    win_d[2][2] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      win_ctrl_q <= '0;
    end else if (adv_i) begin
      win_ctrl_q <= s1_ctrl_q;
      if (s1_ctrl_q.valid) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      win_pc_q <= s1_pc_q;
    end
  end

  // Taps in row-major order, oldest row and oldest column first.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        taps_o[3*i+j] = win_q[i][j];
      end
    end
  end

  assign ctrl_o = win_ctrl_q;
  assign pc_o   = win_pc_q;

endmodule

[rtl/core/c3mp_mac_cell.sv]
module c3mp_mac_cell
  import c3mp_pkg::*;
#(
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8,
  parameter int SUM_W      = 21,
  parameter int PC_W       = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic signed [COEF_BITS-1:0] coef_i,
  input  pool_ctrl_t                  ctrl_i,
  input  logic [PC_W-1:0]             pc_i,
  input  logic signed [SUM_W-1:0]     sum_i,
  input  logic [8:0][PIXEL_BITS-1:0]  taps_i,
  output pool_ctrl_t                  ctrl_o,
  output logic [PC_W-1:0]             pc_o,
  output logic signed [SUM_W-1:0]     sum_o,
  output logic [8:0][PIXEL_BITS-1:0]  taps_o
);

  logic signed [PIXEL_BITS+COEF_BITS:0] prod;
  logic signed [SUM_W-1:0]              sum_d, sum_q;
  pool_ctrl_t                           ctrl_q;
  logic [PC_W-1:0]                      pc_q;
  logic [8:0][PIXEL_BITS-1:0]           taps_q;

  // This cell's tap is always the lowest one; the rest move down a place.
  assign prod  = $signed({1'b0, taps_i[0]}) * coef_i;
  assign sum_d = sum_i + SUM_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pc_q        <= pc_i;
      sum_q       <= sum_d;
      taps_q[7:0] <= taps_i[8:1];
      taps_q[8]   <= '0;
    end
  end

  assign ctrl_o = ctrl_q;
  assign pc_o   = pc_q;
  assign sum_o  = sum_q;
  assign taps_o = taps_q;

endmodule

[rtl/core/c3mp_pool.sv]
module c3mp_pool
  import c3mp_pkg::*;
#(
  parameter int SUM_W = 21,
  parameter int DEPTH = 32,
  parameter int PC_W  = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  pool_ctrl_t                 ctrl_i,
  input  logic [PC_W-1:0]            pc_i,
  input  logic signed [SUM_W-1:0]    sum_i,
  output logic                       out_valid_o,
  output logic signed [OUT_BITS-1:0] pooled_value_o,
  output logic                       row_end_o,
  output logic                       frame_last_o
);

  localparam int XW = (SUM_W > OUT_BITS) ? SUM_W : OUT_BITS;

  logic signed [OUT_BITS-1:0] row_part [DEPTH];

  logic signed [XW-1:0]       sum_x;
  logic signed [OUT_BITS-1:0] sat;
  pool_ctrl_t                 p1_ctrl_q;
  logic [PC_W-1:0]            p1_pc_q;
  logic signed [OUT_BITS-1:0] p1_sat_q, p1_row_q;
  logic signed [OUT_BITS-1:0] left_q, left_d;
  logic signed [OUT_BITS-1:0] left_max;
  logic                       emit;

  logic                       out_valid_q;
  logic signed [OUT_BITS-1:0] pooled_q;
  logic                       row_end_q, frame_last_q;

  // Clamp the convolution sum to the output range.
  always_comb begin
    sum_x = XW'(sum_i);
    if (sum_x > XW'(OUT_MAX)) begin
      sat = OUT_MAX;
    end else if (sum_x < XW'(OUT_MIN)) begin
      sat = OUT_MIN;
    end else begin
      sat = sum_x[OUT_BITS-1:0];
    end
  end

  // First stage: saturated value and the partial of the upper map row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_ctrl_q <= '0;
    end else if (adv_i) begin
      p1_ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_pc_q  <= pc_i;
      p1_sat_q <= sat;
      p1_row_q <= row_part[pc_i];
    end
  end

  assign left_max = pool_max(left_q, p1_sat_q);
  assign emit     = p1_ctrl_q.valid && p1_ctrl_q.act && p1_ctrl_q.odd_row &&
                    p1_ctrl_q.odd_col;

  // The upper row of a block leaves its maximum per pooled column.
  always_ff @(posedge clk_i) begin
    if (adv_i && p1_ctrl_q.valid && p1_ctrl_q.act && !p1_ctrl_q.odd_row &&
        p1_ctrl_q.odd_col) begin
      row_part[p1_pc_q] <= left_max;
    end
  end

  // The left half of the block gathers in a single register.
  always_comb begin
    left_d = left_q;
    if (p1_ctrl_q.valid && p1_ctrl_q.act && !p1_ctrl_q.odd_col) begin
      if (p1_ctrl_q.odd_row) begin
        left_d = pool_max(p1_row_q, p1_sat_q);
      end else begin
        left_d = p1_sat_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      left_q      <= left_d;
      out_valid_q <= emit;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pooled_q     <= left_max;
      row_end_q    <= p1_ctrl_q.row_end;
      frame_last_q <= p1_ctrl_q.frame_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pooled_value_o = pooled_q;
  assign row_end_o      = row_end_q;
  assign frame_last_o   = frame_last_q;

endmodule

[rtl/core/conv3x3_maxpool2x2_stream.sv]
// Results are registered in the line window, every multiply-accumulate cell and the pool.
// Throughput: one pixel per cycle while the output is not stalled, with at most one pooled
// value per four pixels; the nine cells and two line stores each take a beat every cycle.
// Reset clears the position counters, the pixel window and the pool partial, sets the
// width to 64 and the kernel to a Laplacian; line stores and row partials are not cleared.
module conv3x3_maxpool2x2_stream
  import c3mp_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8,
  localparam int KROW_W    = 3 * COEF_BITS,
  localparam int CFG_W     = (KROW_W > IMG_W) ? KROW_W : IMG_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [PIXEL_BITS-1:0]      pixel_value_i,
  input  logic                       frame_start_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_BITS-1:0] pooled_value_o,
  output logic                       row_end_o,
  output logic                       frame_last_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i
);

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int EW     = (WW > IMG_W) ? WW : IMG_W;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int PC_W   = $clog2(DEPTH);
  localparam int SUM_W  = PIXEL_BITS + COEF_BITS + 5;

  localparam logic [KROW_W-1:0] KROW_EDGE_RST = {3{COEF_BITS'(KERNEL_EDGE)}};
  localparam logic [KROW_W-1:0] KROW_MID_RST  =
    {COEF_BITS'(KERNEL_EDGE), COEF_BITS'(KERNEL_CENTRE), COEF_BITS'(KERNEL_EDGE)};

  logic                   adv;
  logic [IMG_W-1:0]       img_w_q;
  logic [2:0][KROW_W-1:0] kern_q;
  logic [EW-1:0]          w_ext;
  logic [WW-1:0]          weff;

  logic [WW-1:0] row_q, col_q, row_d, col_d;
  logic [WW-1:0] r_cur, c_cur;
  logic [WW-1:0] cr, cc, pr, pc_w, p_num;
  pool_ctrl_t    ctrl0;

  pool_ctrl_t                 ctrl_c [10];
  logic [PC_W-1:0]            pc_c   [10];
  logic signed [SUM_W-1:0]    sum_c  [10];
  logic [8:0][PIXEL_BITS-1:0] taps_c [9];
  logic signed [COEF_BITS-1:0] coef_c [9];

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv         = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q   <= IMG_W_RST;
      kern_q[0] <= KROW_EDGE_RST;
      kern_q[1] <= KROW_MID_RST;
      kern_q[2] <= KROW_EDGE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH: img_w_q   <= cfg_data_i[IMG_W-1:0];
        REG_KERNEL_TOP:  kern_q[0] <= cfg_data_i[KROW_W-1:0];
        REG_KERNEL_MID:  kern_q[1] <= cfg_data_i[KROW_W-1:0];
        REG_KERNEL_BOT:  kern_q[2] <= cfg_data_i[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Width in use, held within the supported range.
  always_comb begin
    w_ext = EW'(img_w_q);
    if (w_ext < EW'(MIN_WIDTH)) begin
      w_ext = EW'(MIN_WIDTH);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_ext = EW'(MAX_WIDTH);
    end
  end
  assign weff = w_ext[WW-1:0];

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    r_cur = frame_start_i ? '0 : row_q;
    c_cur = frame_start_i ? '0 : col_q;
    if (c_cur >= weff) begin
      c_cur = '0;
      r_cur = r_cur + 1'b1;
    end
    if (r_cur >= weff) begin
      r_cur = '0;
    end
    if ((c_cur + 1'b1) >= weff) begin
      col_d = '0;
      row_d = ((r_cur + 1'b1) >= weff) ? '0 : r_cur + 1'b1;
    end else begin
      col_d = c_cur + 1'b1;
      row_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_valid_i && adv) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Place of the pixel's convolution result within the pooled grid.
  assign cr    = r_cur - WW'(2);
  assign cc    = c_cur - WW'(2);
  assign pr    = cr >> 1;
  assign pc_w  = cc >> 1;
  assign p_num = (weff - WW'(2)) >> 1;

  always_comb begin
    ctrl0.valid      = in_valid_i;
    ctrl0.act        = (r_cur >= WW'(2)) && (c_cur >= WW'(2)) &&
                       (pr < p_num) && (pc_w < p_num);
    ctrl0.odd_row    = cr[0];
    ctrl0.odd_col    = cc[0];
    ctrl0.row_end    = (pc_w == p_num - 1'b1);
    ctrl0.frame_last = (pc_w == p_num - 1'b1) && (pr == p_num - 1'b1);
  end

  c3mp_line_window #(
    .PIXEL_BITS (PIXEL_BITS),
    .MAX_WIDTH  (MAX_WIDTH),
    .PC_W       (PC_W),
    .ADDR_W     (ADDR_W)
  ) u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctrl_i  (ctrl0),
    .pc_i    (pc_w[PC_W-1:0]),
    .addr_i  (c_cur[ADDR_W-1:0]),
    .pixel_i (pixel_value_i),
    .ctrl_o  (ctrl_c[0]),
    .pc_o    (pc_c[0]),
    .taps_o  (taps_c[0])
  );

  assign sum_c[0] = '0;

  // Multiply-accumulate chain, one kernel tap per cell.
  for (genvar k = 0; k < 9; k++) begin : g_cell
    assign coef_c[k] = $signed(kern_q[k/3][(2 - (k % 3)) * COEF_BITS +: COEF_BITS]);

    if (k < 8) begin : g_mid
      c3mp_mac_cell #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS),
        .SUM_W      (SUM_W),
        .PC_W       (PC_W)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .adv_i  (adv),
        .coef_i (coef_c[k]),
        .ctrl_i (ctrl_c[k]),
        .pc_i   (pc_c[k]),
        .sum_i  (sum_c[k]),
        .taps_i (taps_c[k]),
        .ctrl_o (ctrl_c[k+1]),
        .pc_o   (pc_c[k+1]),
        .sum_o  (sum_c[k+1]),
        .taps_o (taps_c[k+1])
      );
    end else begin : g_last
      c3mp_mac_cell #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS),
        .SUM_W      (SUM_W),
        .PC_W       (PC_W)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .adv_i  (adv),
        .coef_i (coef_c[k]),
        .ctrl_i (ctrl_c[k]),
        .pc_i   (pc_c[k]),
        .sum_i  (sum_c[k]),
        .taps_i (taps_c[k]),
        .ctrl_o (ctrl_c[k+1]),
        .pc_o   (pc_c[k+1]),
        .sum_o  (sum_c[k+1]),
        .taps_o ()
      );
    end
  end

  c3mp_pool #(
    .SUM_W (SUM_W),
    .DEPTH (DEPTH),
    .PC_W  (PC_W)
  ) u_pool (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .ctrl_i         (ctrl_c[9]),
    .pc_i           (pc_c[9]),
    .sum_i          (sum_c[9]),
    .out_valid_o    (out_valid_o),
    .pooled_value_o (pooled_value_o),
    .row_end_o      (row_end_o),
    .frame_last_o   (frame_last_o)
  );

endmodule
